// ===== src/dwrd_pkg.sv =====
// ----------------------------------------------------------------------------
// dwrd_pkg: shared types and constants
// Holds operation codes, cell commands, controller states and payload widths
// for the double-ended queue with reverse and delete.
// ----------------------------------------------------------------------------
package dwrd_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int COUNT_W      = 5;
    localparam int CAPACITY_DEF = 16;

    // operation codes of an input item
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_DELETE     = 3'd3,
        OP_REVERSE    = 3'd4,
        OP_DUMP       = 3'd5
    } t_op;

    // command broadcast to every cell of the chain
    typedef enum logic [3:0] {
        CMD_HOLD,   // keep contents
        CMD_SHR,    // shift toward the back, front cell takes the new value
        CMD_LOAD,   // the cell at the occupancy index takes the new value
        CMD_SHL,    // shift toward the front
        CMD_MATCH,  // register compare against the value
        CMD_DEL,    // shift toward the front from the first match onward
        CMD_REV,    // main shifts to the front, aux shifts to the back
        CMD_COPY,   // main takes aux
        CMD_ROT     // rotate the occupied cells toward the front
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd               cmd;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELETE,
        ST_REVERSE,
        ST_COPY,
        ST_DUMP
    } t_state;

endpackage

// ===== src/dwrd_if.sv =====
// ----------------------------------------------------------------------------
// dwrd_if: item channels
// Valid/ready channels for the operation items going in and the result
// items coming out.
// ----------------------------------------------------------------------------
interface dwrd_cmd_if;
    logic                                     valid;
    logic                                     ready;
    logic [dwrd_pkg::OP_W-1:0]                operation;
    logic signed [dwrd_pkg::DATA_W-1:0]       value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface dwrd_res_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [dwrd_pkg::DATA_W-1:0]       entry;
    logic                                     last;
    logic                                     empty_res;
    logic                                     overflow;
    logic [dwrd_pkg::COUNT_W-1:0]             count;

    modport source (output valid, output entry, output last, output empty_res,
                    output overflow, output count, input ready);
    modport sink   (input valid, input entry, input last, input empty_res,
                    input overflow, input count, output ready);
endinterface

// ===== src/dwrd_cell.sv =====
// ----------------------------------------------------------------------------
// dwrd_cell: one queue slot
// Holds one entry plus a scratch word used while reversing, and trades them
// with its neighbors under the broadcast command.
// ----------------------------------------------------------------------------
module dwrd_cell #(
    parameter int CAPACITY = dwrd_pkg::CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  logic                                      i_clk,
    input  dwrd_pkg::t_cell_ctl                       i_ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]             i_occ,
    input  logic signed [dwrd_pkg::DATA_W-1:0]        i_left_main,
    input  logic signed [dwrd_pkg::DATA_W-1:0]        i_left_aux,
    input  logic signed [dwrd_pkg::DATA_W-1:0]        i_right_main,
    input  logic signed [dwrd_pkg::DATA_W-1:0]        i_front,
    input  logic                                      i_found,
    output logic signed [dwrd_pkg::DATA_W-1:0]        o_main,
    output logic signed [dwrd_pkg::DATA_W-1:0]        o_aux,
    output logic                                      o_found
);
    import dwrd_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam logic [OCC_W-1:0] MY_IDX   = OCC_W'(IDX);
    localparam logic [OCC_W-1:0] NEXT_IDX = OCC_W'(IDX + 1);

    logic signed [DATA_W-1:0] r_main, n_main;
    logic signed [DATA_W-1:0] r_aux,  n_aux;
    logic                     r_match, n_match;
    logic                     w_take;

    // first match at or ahead of this cell
    assign w_take  = i_found | r_match;
    assign o_found = w_take;
    assign o_main  = r_main;
    assign o_aux   = r_aux;

    // decode the broadcast command
    always_comb begin
        n_main  = r_main;
        n_aux   = r_aux;
        n_match = r_match;
        unique case (i_ctl.cmd)
            CMD_HOLD: begin
            end
            CMD_SHR: begin
                n_main = i_left_main;
            end
            CMD_LOAD: begin
                if (i_occ == MY_IDX) begin
                    n_main = i_ctl.value;
                end
            end
            CMD_SHL: begin
                n_main = i_right_main;
            end
            CMD_MATCH: begin
                n_match = (MY_IDX < i_occ) && (r_main == i_ctl.value);
            end
            CMD_DEL: begin
                if (w_take) begin
                    n_main = i_right_main;
                end
            end
            CMD_REV: begin
                n_main = i_right_main;
                n_aux  = i_left_aux;
            end
            CMD_COPY: begin
                n_main = r_aux;
            end
            CMD_ROT: begin
                n_main = (i_occ == NEXT_IDX) ? i_front : i_right_main;
            end
            default: begin
            end
        endcase
    end

    // hold the slot contents
    always_ff @(posedge i_clk) begin
        r_main  <= n_main;
        r_aux   <= n_aux;
        r_match <= n_match;
    end

endmodule

// ===== src/dwrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwrd_ctrl: queue sequencer
// Takes operation items, steers the cell chain, tracks the occupancy and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module dwrd_ctrl #(
    parameter int CAPACITY = dwrd_pkg::CAPACITY_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    dwrd_cmd_if.sink                              i_cmd,
    dwrd_res_if.source                            o_res,
    input  logic signed [dwrd_pkg::DATA_W-1:0]    i_front,
    input  logic                                  i_found,
    output dwrd_pkg::t_cell_ctl                   o_ctl,
    output logic [$clog2(CAPACITY+1)-1:0]         o_occ
);
    import dwrd_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam logic [OCC_W-1:0] FULL = OCC_W'(CAPACITY);
    localparam logic [OCC_W-1:0] ONE  = OCC_W'(1);

    t_state                   r_state, n_state;
    logic [OCC_W-1:0]         r_occ, n_occ;
    logic [OCC_W-1:0]         r_step, n_step;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_entry, n_entry;
    logic                     r_last, n_last;
    logic                     r_empty, n_empty;
    logic                     r_ovf, n_ovf;
    logic [COUNT_W-1:0]       r_count, n_count;
    logic                     w_load;
    logic                     w_out_free;
    logic                     w_accept;
    logic                     w_step_end;
    t_op                      w_op;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_op       = t_op'(i_cmd.operation);
    assign w_step_end = (r_step == r_occ - ONE);

    assign i_cmd.ready     = (r_state == ST_IDLE) && w_out_free;
    assign o_res.valid     = r_out_valid;
    assign o_res.entry     = r_entry;
    assign o_res.last      = r_last;
    assign o_res.empty_res = r_empty;
    assign o_res.overflow  = r_ovf;
    assign o_res.count     = r_count;
    assign o_occ           = r_occ;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_DELETE:  n_state = ST_DELETE;
                        OP_REVERSE: n_state = (r_occ > ONE) ? ST_REVERSE : ST_IDLE;
                        OP_DUMP:    n_state = (r_occ != '0) ? ST_DUMP : ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DELETE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REVERSE: begin
                if (w_step_end) begin
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (w_out_free && w_step_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs: cell command, occupancy, result
    always_comb begin
        o_ctl.cmd   = CMD_HOLD;
        o_ctl.value = i_cmd.value;
        n_occ       = r_occ;
        n_step      = r_step;
        w_load      = 1'b0;
        n_entry     = '0;
        n_last      = 1'b1;
        n_ovf       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (w_accept) begin
                    w_load = 1'b1;
                    case (w_op)
                        OP_PUSH_FRONT: begin
                            if (r_occ >= FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                o_ctl.cmd = CMD_SHR;
                                n_occ     = r_occ + ONE;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (r_occ >= FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                o_ctl.cmd = CMD_LOAD;
                                n_occ     = r_occ + ONE;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (r_occ != '0) begin
                                o_ctl.cmd = CMD_SHL;
                                n_occ     = r_occ - ONE;
                            end
                        end
                        OP_DELETE: begin
                            o_ctl.cmd = CMD_MATCH;
                            w_load    = 1'b0;
                        end
                        OP_REVERSE: begin
                            w_load = (r_occ <= ONE);
                        end
                        OP_DUMP: begin
                            w_load = (r_occ == '0);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DELETE: begin
                if (w_out_free) begin
                    o_ctl.cmd = CMD_DEL;
                    w_load    = 1'b1;
                    if (i_found) begin
                        n_occ = r_occ - ONE;
                    end
                end
            end
            ST_REVERSE: begin
                o_ctl.cmd = CMD_REV;
                n_step    = r_step + ONE;
            end
            ST_COPY: begin
                if (w_out_free) begin
                    o_ctl.cmd = CMD_COPY;
                    w_load    = 1'b1;
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    o_ctl.cmd = CMD_ROT;
                    w_load    = 1'b1;
                    n_entry   = i_front;
                    n_last    = w_step_end;
                    n_step    = r_step + ONE;
                end
            end
            default: begin
            end
        endcase
        n_empty = (n_occ == '0);
        n_count = COUNT_W'(n_occ);
    end

    // advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_step  <= n_step;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_entry <= n_entry;
            r_last  <= n_last;
            r_empty <= n_empty;
            r_ovf   <= n_ovf;
            r_count <= n_count;
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL)
        else $error("occupancy above capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_PUSH_FRONT || w_op == OP_PUSH_BACK) && r_occ < FULL)
        |=> r_occ == $past(r_occ) + ONE)
        else $error("push did not add an entry");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DELETE) |=> r_occ <= $past(r_occ))
        else $error("delete raised occupancy");

    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP && w_load && n_last) |=> r_state == ST_IDLE)
        else $error("dump went on past the back entry");

endmodule

// ===== src/deque_with_reverse_and_delete.sv =====
// Push, pop and unused codes: the status result is registered when the item is accepted.
// Delete: compare in every occupied cell, then shift the entries behind the first match to the front.
// Reverse: ST_REVERSE, the cell chain stepping one entry a cycle, then ST_COPY (only a result below two).
// Dump: after the accept, one entry per cycle while the result channel takes them (only a result when empty).
// A stalled result channel holds back new items and the delete, copy and dump steps; one item is in work at a time.
// Reset (synchronous, active low) empties the queue; cell contents are not cleared.
// ----------------------------------------------------------------------------
// deque_with_reverse_and_delete: bounded double-ended queue
// A chain of cells holds the entries front to back; a sequencer drives
// push, pop, delete, reverse and dump over the chain.
// ----------------------------------------------------------------------------
module deque_with_reverse_and_delete #(
    parameter int CAPACITY = dwrd_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dwrd_cmd_if.sink    i_cmd,
    dwrd_res_if.source  o_res
);
    import dwrd_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_cell_ctl                w_ctl;
    logic [OCC_W-1:0]         w_occ;
    logic signed [DATA_W-1:0] w_main [CAPACITY];
    logic signed [DATA_W-1:0] w_aux  [CAPACITY];
    logic                     w_found [CAPACITY];

    dwrd_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .i_front (w_main[0]),
        .i_found (w_found[CAPACITY-1]),
        .o_ctl   (w_ctl),
        .o_occ   (w_occ)
    );

    // chain the cells front to back
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left_main;
        logic signed [DATA_W-1:0] w_left_aux;
        logic signed [DATA_W-1:0] w_right_main;
        logic                     w_found_in;

        if (g == 0) begin : g_head
            assign w_left_main = w_ctl.value;
            assign w_left_aux  = w_main[0];
            assign w_found_in  = 1'b0;
        end else begin : g_body
            assign w_left_main = w_main[g-1];
            assign w_left_aux  = w_aux[g-1];
            assign w_found_in  = w_found[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_main = w_main[g];
        end else begin : g_mid
            assign w_right_main = w_main[g+1];
        end

        dwrd_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occ        (w_occ),
            .i_left_main  (w_left_main),
            .i_left_aux   (w_left_aux),
            .i_right_main (w_right_main),
            .i_front      (w_main[0]),
            .i_found      (w_found_in),
            .o_main       (w_main[g]),
            .o_aux        (w_aux[g]),
            .o_found      (w_found[g])
        );
    end

endmodule
